// File: hw/rtl/wrcp_pkg.sv
// wrcp_pkg: types and constants shared by the wav riff chunk parser modules
// no dependencies

package wrcp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_ID,
    PH_SIZE,
    PH_FMT_BODY,
    PH_FMT_COUNT,
    PH_FMT_EXTRA,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_FMT       = 2'd0;
  localparam logic [1:0] KIND_DATA_HDR  = 2'd1;
  localparam logic [1:0] KIND_DATA_BYTE = 2'd2;

  localparam logic [23:0] ID_FMT3   = 24'h666D74;
  localparam logic [31:0] ID_DATA   = 32'h64617461;
  localparam logic [31:0] FMT_FIXED = 32'd16;
  localparam logic [30:0] RIFF_LAST = 31'd11;
  localparam logic [30:0] FMT_LAST  = 31'd15;
  localparam logic [30:0] WORD_LAST = 31'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [30:0] data_size;
    logic [7:0]  sample_byte;
    logic [30:0] byte_index;
    logic        parse_done;
  } result_t;

endpackage

// File: hw/rtl/wav_riff_chunk_parser.sv
// wav_riff_chunk_parser: top level of the byte-serial wav chunk parser
// depends on wrcp_pkg, wrcp_in_reg, wrcp_core and wrcp_out_reg
//
// usage
//   input: one file byte per request on in_byte, in_valid / in_stall
//   output: at most one result per byte on kind and the value fields,
//     out_valid / out_stall; kind 0 format record, 1 data header,
//     2 data byte with its index; parse_done marks the result that
//     completes both the format and data chunks
//   the first 12 bytes are the riff header and give no result; after
//     parse_done every byte is taken and dropped until reset
//   throughput: one byte per cycle unless out_stall holds a result, set
//     by the combinational parser step between input and result registers
//   path: a byte accepted into the input register has its result loaded
//     into the result register, which drives out_valid
//   reset: rst clears both registers' valid flags and returns the
//     parser to the riff header
//   while out_stall is high and a result is held, the parser step waits;
//     the input register still takes a byte if empty, then in_stall rises

module wav_riff_chunk_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] num_channels,
  output logic [31:0] sample_rate,
  output logic [15:0] bits_per_sample,
  output logic [30:0] data_size,
  output logic [7:0]  sample_byte,
  output logic [30:0] byte_index,
  output logic        parse_done
);

  import wrcp_pkg::*;

  logic    held_valid;
  logic [7:0] held_byte;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign step = held_valid && (!out_valid || !out_stall);

  wrcp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wrcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wrcp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_valid (res_valid),
    .load_data  (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  assign kind            = out_data.kind;
  assign num_channels    = out_data.num_channels;
  assign sample_rate     = out_data.sample_rate;
  assign bits_per_sample = out_data.bits_per_sample;
  assign data_size       = out_data.data_size;
  assign sample_byte     = out_data.sample_byte;
  assign byte_index      = out_data.byte_index;
  assign parse_done      = out_data.parse_done;

endmodule

// File: hw/rtl/wrcp_in_reg.sv
// wrcp_in_reg: input register for the byte stream
// holds one request until the parser core takes it; no package use

module wrcp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic load;

  assign load     = in_valid && !in_stall;
  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= in_byte;
    end
  end

endmodule

// File: hw/rtl/wrcp_core.sv
// wrcp_core: chunk parser state and combinational step logic
// uses wrcp_pkg for phase type, ids and the result struct

module wrcp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output wrcp_pkg::result_t res
);

  import wrcp_pkg::*;

  phase_t      phase, phase_next;
  logic [30:0] byte_count, byte_count_next;
  logic [31:0] chunk_id, chunk_id_next;
  logic [31:0] assembled_value, assembled_value_next;
  logic [30:0] remaining_bytes, remaining_bytes_next;
  logic        fmt_seen, fmt_seen_next;
  logic        data_seen, data_seen_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [15:0] held_bps, held_bps_next;
  logic        fmt_extra, fmt_extra_next;

  logic [30:0] cnt_inc;
  logic [30:0] rem_dec;
  logic [31:0] size_word;
  logic [30:0] usable;
  logic [15:0] word16;
  logic        id_last, size_last, body_end, count_end, rem_last;
  logic        is_fmt, is_data, sz_zero;
  logic        fmt_finish, data_finish, skip_finish, chunk_end, all_seen;
  phase_t      chunk_phase;

  assign cnt_inc   = byte_count + 31'd1;
  assign rem_dec   = remaining_bytes - 31'd1;
  assign size_word = {in_byte, assembled_value[31:8]};
  assign usable    = size_word[31] ? 31'd0 : size_word[30:0];
  assign word16    = {in_byte, assembled_value[15:8]};
  assign sz_zero   = (usable == 31'd0);
  assign is_fmt    = (chunk_id[31:8] == ID_FMT3);
  assign is_data   = (chunk_id == ID_DATA);

  assign id_last   = (phase == PH_ID) && (byte_count == WORD_LAST);
  assign size_last = (phase == PH_SIZE) && (byte_count == WORD_LAST);
  assign body_end  = (phase == PH_FMT_BODY) && (byte_count == FMT_LAST);
  assign count_end = (phase == PH_FMT_COUNT) && byte_count[0];
  assign rem_last  = (remaining_bytes == 31'd1);

  assign fmt_finish  = (body_end && !fmt_extra) ||
                       (count_end && (word16 == 16'd0)) ||
                       ((phase == PH_FMT_EXTRA) && rem_last);
  assign data_finish = (size_last && !is_fmt && is_data && sz_zero) ||
                       ((phase == PH_DATA) && rem_last);
  assign skip_finish = (size_last && !is_fmt && !is_data && sz_zero) ||
                       ((phase == PH_SKIP) && rem_last);
  assign chunk_end   = fmt_finish || data_finish || skip_finish;
  assign all_seen    = (fmt_seen || fmt_finish) && (data_seen || data_finish);
  assign chunk_phase = all_seen ? PH_DONE : PH_ID;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_RIFF: begin
        if (byte_count == RIFF_LAST) phase_next = PH_ID;
      end
      PH_ID: begin
        if (id_last) phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        if (size_last) begin
          if (is_fmt) phase_next = PH_FMT_BODY;
          else if (is_data) phase_next = PH_DATA;
          else phase_next = PH_SKIP;
        end
      end
      PH_FMT_BODY: begin
        if (body_end && fmt_extra) phase_next = PH_FMT_COUNT;
      end
      PH_FMT_COUNT: begin
        if (count_end) phase_next = PH_FMT_EXTRA;
      end
      default: begin
        phase_next = phase;
      end
    endcase
    if (chunk_end) phase_next = chunk_phase;
  end

  // datapath and result
  always_comb begin
    byte_count_next      = byte_count;
    chunk_id_next        = chunk_id;
    assembled_value_next = assembled_value;
    remaining_bytes_next = remaining_bytes;
    fmt_seen_next        = fmt_seen;
    data_seen_next       = data_seen;
    held_channels_next   = held_channels;
    held_rate_next       = held_rate;
    held_bps_next        = held_bps;
    fmt_extra_next       = fmt_extra;
    res_valid            = 1'b0;
    res                  = '0;
    case (phase)
      PH_RIFF: begin
        byte_count_next = (byte_count == RIFF_LAST) ? 31'd0 : cnt_inc;
        if (byte_count == RIFF_LAST) chunk_id_next = '0;
      end
      PH_ID: begin
        chunk_id_next   = {chunk_id[23:0], in_byte};
        byte_count_next = id_last ? 31'd0 : cnt_inc;
        if (id_last) assembled_value_next = '0;
      end
      PH_SIZE: begin
        assembled_value_next = size_word;
        byte_count_next      = size_last ? 31'd0 : cnt_inc;
        if (size_last) begin
          if (is_fmt) begin
            fmt_extra_next       = !size_word[31] && (size_word > FMT_FIXED);
            held_channels_next   = '0;
            held_rate_next       = '0;
            assembled_value_next = '0;
          end else if (is_data) begin
            res_valid            = 1'b1;
            res.kind             = KIND_DATA_HDR;
            res.data_size        = usable;
            remaining_bytes_next = usable;
            if (sz_zero) data_seen_next = 1'b1;
          end else begin
            remaining_bytes_next = usable;
          end
        end
      end
      PH_FMT_BODY: begin
        byte_count_next = body_end ? 31'd0 : cnt_inc;
        if (byte_count == 31'd2 || byte_count == 31'd3) begin
          held_channels_next = {in_byte, held_channels[15:8]};
        end
        if (byte_count >= 31'd4 && byte_count <= 31'd7) begin
          held_rate_next = {in_byte, held_rate[31:8]};
        end
        if (byte_count == 31'd14 || byte_count == FMT_LAST) begin
          assembled_value_next = {16'd0, word16};
        end
        if (body_end && fmt_extra) begin
          held_bps_next        = word16;
          assembled_value_next = '0;
        end
      end
      PH_FMT_COUNT: begin
        assembled_value_next = {16'd0, word16};
        byte_count_next      = count_end ? 31'd0 : cnt_inc;
        if (count_end) remaining_bytes_next = {15'd0, word16};
      end
      PH_FMT_EXTRA: begin
        remaining_bytes_next = rem_dec;
      end
      PH_DATA: begin
        res_valid            = 1'b1;
        res.kind             = KIND_DATA_BYTE;
        res.sample_byte      = in_byte;
        res.byte_index       = byte_count;
        byte_count_next      = cnt_inc;
        remaining_bytes_next = rem_dec;
        if (rem_last) data_seen_next = 1'b1;
      end
      PH_SKIP: begin
        remaining_bytes_next = rem_dec;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (fmt_finish) begin
      fmt_seen_next       = 1'b1;
      res_valid           = 1'b1;
      res.kind            = KIND_FMT;
      res.num_channels    = held_channels;
      res.sample_rate     = held_rate;
      res.bits_per_sample = body_end ? word16 : held_bps;
    end
    if (chunk_end) begin
      byte_count_next = '0;
      chunk_id_next   = '0;
    end
    res.parse_done = res_valid && all_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      byte_count      <= '0;
      chunk_id        <= '0;
      assembled_value <= '0;
      remaining_bytes <= '0;
      fmt_seen        <= 1'b0;
      data_seen       <= 1'b0;
      held_channels   <= '0;
      held_rate       <= '0;
      held_bps        <= '0;
      fmt_extra       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      chunk_id        <= chunk_id_next;
      assembled_value <= assembled_value_next;
      remaining_bytes <= remaining_bytes_next;
      fmt_seen        <= fmt_seen_next;
      data_seen       <= data_seen_next;
      held_channels   <= held_channels_next;
      held_rate       <= held_rate_next;
      held_bps        <= held_bps_next;
      fmt_extra       <= fmt_extra_next;
    end
  end

endmodule

// File: hw/rtl/wrcp_out_reg.sv
// wrcp_out_reg: result register toward the receiver
// uses wrcp_pkg for the result struct

module wrcp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  wrcp_pkg::result_t load_data,
  input  logic              out_stall,
  output logic              out_valid,
  output wrcp_pkg::result_t out_data
);

  import wrcp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule
